// ----- hw/rtl/sobel_edge_magnitude_unit_assert.svh -----
// Assertion macros shared by the Sobel edge magnitude RTL
`ifndef SOBEL_EDGE_MAGNITUDE_UNIT_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define SEM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define SEM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/sem_pkg.sv -----
// Package: constants and types of the Sobel edge magnitude unit
package sem_pkg;

  localparam int unsigned SEM_MAX_LINE  = 1024;
  localparam int unsigned SEM_RESET_DIM = 400;
  localparam int unsigned SEM_MIN_DIM   = 3;
  localparam int unsigned SEM_PIX_W     = 8;
  localparam int unsigned SEM_CFG_W     = 11;
  localparam int unsigned SEM_GRAD_W    = 10;
  localparam int unsigned SEM_EDGE_MAX  = 255;

  // Configuration register indexes
  typedef enum logic {
    SEM_REG_LINE_LENGTH = 1'b0,
    SEM_REG_LINE_COUNT  = 1'b1
  } sem_reg_e;

  // Pixels of the 3x3 window used by the gradients (centre pixel has weight zero)
  typedef struct packed {
    logic [SEM_PIX_W-1:0] l0;
    logic [SEM_PIX_W-1:0] l1;
    logic [SEM_PIX_W-1:0] l2;
    logic [SEM_PIX_W-1:0] m0;
    logic [SEM_PIX_W-1:0] m2;
    logic [SEM_PIX_W-1:0] r0;
    logic [SEM_PIX_W-1:0] r1;
    logic [SEM_PIX_W-1:0] r2;
  } sem_win_t;

  // Position flags carried with a result
  typedef struct packed {
    logic line_end;
    logic frame_end;
  } sem_flags_t;

endpackage

// ----- hw/rtl/sem_line_buf.sv -----
// Line buffer memory: two scan lines per column entry, registered read with write forwarding
module sem_line_buf import sem_pkg::*; #(
  parameter int unsigned MaxLine = SEM_MAX_LINE,
  localparam int unsigned AddrW  = $clog2(MaxLine),
  localparam int unsigned DataW  = 2 * SEM_PIX_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [DataW-1:0] wr_data_i,
  output logic [DataW-1:0] rd_data_o
);

  logic [DataW-1:0] mem [MaxLine];
  logic [DataW-1:0] rd_q;
  logic [DataW-1:0] fwd_data_q;
  logic             fwd_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, old data on a same-edge write
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q       <= mem[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

  // Note a write to the entry being read at the same edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rd_q;

endmodule

// ----- hw/rtl/sem_grad.sv -----
// Gradient stage and output register: |Gx| + |Gy| saturated to 8 bits
module sem_grad import sem_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  logic                 prod_i,
  input  sem_win_t             win_i,
  input  sem_flags_t           flags_i,
  output logic                 free_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [SEM_PIX_W-1:0] edge_value_o,
  output logic                 line_end_o,
  output logic                 frame_end_o
);

  `include "sobel_edge_magnitude_unit_assert.svh"

  logic [SEM_GRAD_W-1:0] sum_a, sum_b, sum_c, sum_d;
  logic [SEM_GRAD_W-1:0] gx_d, gy_d, gx_q, gy_q;
  logic [SEM_GRAD_W:0]   mag;
  logic                  s2_v_q, out_v_q, out_free;
  sem_flags_t            s2_flags_q, out_flags_q;
  logic [SEM_PIX_W-1:0]  edge_d, edge_q;

  // Weighted column and row sums
  assign sum_a = SEM_GRAD_W'(win_i.r0) + {1'b0, win_i.r1, 1'b0} + SEM_GRAD_W'(win_i.r2);
  assign sum_b = SEM_GRAD_W'(win_i.l0) + {1'b0, win_i.l1, 1'b0} + SEM_GRAD_W'(win_i.l2);
  assign sum_c = SEM_GRAD_W'(win_i.l2) + {1'b0, win_i.m2, 1'b0} + SEM_GRAD_W'(win_i.r2);
  assign sum_d = SEM_GRAD_W'(win_i.l0) + {1'b0, win_i.m0, 1'b0} + SEM_GRAD_W'(win_i.r0);

  // Absolute differences
  assign gx_d = (sum_a >= sum_b) ? (sum_a - sum_b) : (sum_b - sum_a);
  assign gy_d = (sum_c >= sum_d) ? (sum_c - sum_d) : (sum_d - sum_c);

  // Magnitude and saturation
  assign mag    = {1'b0, gx_q} + {1'b0, gy_q};
  assign edge_d = (mag > (SEM_GRAD_W+1)'(SEM_EDGE_MAX)) ? SEM_PIX_W'(SEM_EDGE_MAX)
                                                         : SEM_PIX_W'(mag);

  assign out_free = !out_v_q || out_ready_i;
  assign free_o   = !s2_v_q || out_free;

  // Advance valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (free_o) begin
        s2_v_q <= load_i && prod_i;
      end
      if (out_free) begin
        out_v_q <= s2_v_q;
      end
    end
  end

  // Hold payload while stalled
  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      gx_q       <= gx_d;
      gy_q       <= gy_d;
      s2_flags_q <= flags_i;
    end
    if (out_free && s2_v_q) begin
      edge_q      <= edge_d;
      out_flags_q <= s2_flags_q;
    end
  end

  assign out_valid_o  = out_v_q;
  assign edge_value_o = edge_q;
  assign line_end_o   = out_flags_q.line_end;
  assign frame_end_o  = out_flags_q.frame_end;

  `SEM_ASSERT_IMPL(a_fend_lend, out_v_q && out_flags_q.frame_end, out_flags_q.line_end,
                   "frame end without line end")
  `SEM_ASSERT_NEXT(a_out_hold, out_v_q && !out_ready_i, out_v_q,
                   "result dropped while stalled")

endmodule

// ----- hw/rtl/sobel_edge_magnitude_unit.sv -----
// Sobel 3x3 edge detector, L1 magnitude: takes one pixel per clock in scan order unless
// the output stalls and gives one saturated |Gx|+|Gy| result per full 3x3 window,
// (line_length-2) x (line_count-2) results per frame, the first two rows and columns
// giving none. Throughput is one pixel per cycle sustained while the output is not
// stalled; a result passes the memory read, gradient and output registers in turn.
// The two previous lines sit in one memory of MaxLine entries holding both lines per
// column; each pixel reads its column and writes it back when the read stage advances,
// with forwarding when a restarted frame hits the column still being written. No
// clearing pass is needed after reset. Writing line_length or line_count (clamped to
// 3..MaxLine) restarts the frame; frame_start does the same for its pixel.
module sobel_edge_magnitude_unit import sem_pkg::*; #(
  parameter int unsigned MaxLine = SEM_MAX_LINE
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [SEM_PIX_W-1:0] pixel_i,
  input  logic                 frame_start_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [SEM_PIX_W-1:0] edge_value_o,
  output logic                 line_end_o,
  output logic                 frame_end_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  `include "sobel_edge_magnitude_unit_assert.svh"

  localparam int unsigned ColW    = $clog2(MaxLine);
  localparam int unsigned RstDim  = (SEM_RESET_DIM < MaxLine) ? SEM_RESET_DIM : MaxLine;
  localparam logic [ColW-1:0] RstLast = ColW'(RstDim - 1);

  logic [ColW-1:0]      col_last_q, row_last_q;
  logic [ColW-1:0]      col_q, col_d, row_q, row_d;
  logic [ColW-1:0]      cur_col, cur_row;
  logic                 acc, cfg_wr, at_line_end, at_frame_end;
  logic [31:0]          cfg_val, cfg_dim;
  logic [ColW-1:0]      cfg_last;
  sem_reg_e             cfg_sel;

  logic                 s1_v_q, s1_prod_q, s1_go, s2_free;
  logic [SEM_PIX_W-1:0] s1_px_q;
  logic [ColW-1:0]      s1_col_q;
  sem_flags_t           s1_flags_q;
  logic [2*SEM_PIX_W-1:0] rd_data;
  logic [SEM_PIX_W-1:0] top, mid;
  logic [SEM_PIX_W-1:0] w_q [6];
  sem_win_t             win;

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_sel = sem_reg_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_val = {{(32-SEM_CFG_W){1'b0}}, pwdata[SEM_CFG_W-1:0]};
  assign cfg_dim = (cfg_val < SEM_MIN_DIM) ? 32'(SEM_MIN_DIM)
                 : (cfg_val > MaxLine) ? 32'(MaxLine) : cfg_val;
  assign cfg_last = ColW'(cfg_dim - 32'd1);

  always_comb begin
    case (cfg_sel)
      SEM_REG_LINE_LENGTH: prdata = 32'(col_last_q) + 32'd1;
      SEM_REG_LINE_COUNT:  prdata = 32'(row_last_q) + 32'd1;
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_last_q <= RstLast;
      row_last_q <= RstLast;
    end else if (cfg_wr) begin
      case (cfg_sel)
        SEM_REG_LINE_LENGTH: col_last_q <= cfg_last;
        SEM_REG_LINE_COUNT:  row_last_q <= cfg_last;
        default: ;
      endcase
    end
  end

  // Position of the incoming pixel and the next one
  assign acc          = in_valid_i && in_ready_o;
  assign cur_col      = frame_start_i ? '0 : col_q;
  assign cur_row      = frame_start_i ? '0 : row_q;
  assign at_line_end  = (cur_col == col_last_q);
  assign at_frame_end = at_line_end && (cur_row == row_last_q);

  always_comb begin
    col_d = cur_col + ColW'(1);
    row_d = cur_row;
    if (at_line_end) begin
      col_d = '0;
      row_d = (cur_row == row_last_q) ? '0 : cur_row + ColW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_wr) begin
      col_q <= '0;
      row_q <= '0;
    end else if (acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Memory read stage
  assign in_ready_o = !s1_v_q || s2_free;
  assign s1_go      = s1_v_q && s2_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_v_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_px_q    <= pixel_i;
      s1_col_q   <= cur_col;
      s1_prod_q  <= (cur_row >= ColW'(2)) && (cur_col >= ColW'(2));
      s1_flags_q <= '{line_end: at_line_end, frame_end: at_frame_end};
    end
  end

  sem_line_buf #(
    .MaxLine (MaxLine)
  ) u_line_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (acc),
    .rd_addr_i (cur_col),
    .wr_en_i   (s1_go),
    .wr_addr_i (s1_col_q),
    .wr_data_i ({mid, s1_px_q}),
    .rd_data_o (rd_data)
  );

  assign top = rd_data[2*SEM_PIX_W-1:SEM_PIX_W];
  assign mid = rd_data[SEM_PIX_W-1:0];

  // Shift the window by one column per transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        w_q[i] <= '0;
      end
    end else if (s1_go) begin
      w_q[0] <= w_q[3];
      w_q[1] <= w_q[4];
      w_q[2] <= w_q[5];
      w_q[3] <= top;
      w_q[4] <= mid;
      w_q[5] <= s1_px_q;
    end
  end

  assign win = '{l0: w_q[0], l1: w_q[1], l2: w_q[2], m0: w_q[3], m2: w_q[5],
                 r0: top, r1: mid, r2: s1_px_q};

  sem_grad u_grad (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (s1_go),
    .prod_i       (s1_prod_q),
    .win_i        (win),
    .flags_i      (s1_flags_q),
    .free_o       (s2_free),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .edge_value_o (edge_value_o),
    .line_end_o   (line_end_o),
    .frame_end_o  (frame_end_o)
  );

  `SEM_ASSERT_IMPL(a_dim_range, 1'b1, col_last_q >= ColW'(2) && row_last_q >= ColW'(2),
                   "line dimension below three")
  `SEM_ASSERT_IMPL(a_pos_range, 1'b1, col_q <= col_last_q && row_q <= row_last_q,
                   "pixel position outside the frame")
  `SEM_ASSERT_NEXT(a_s1_hold, s1_v_q && !s2_free, s1_v_q && $stable(s1_col_q),
                   "stalled pixel lost from read stage")

endmodule
